// ----- rtl/core/linear_gradient_color_defines.svh -----
// Assertion macros for the linear gradient color top module.
`ifndef LINEAR_GRADIENT_COLOR_DEFINES_SVH
`define LINEAR_GRADIENT_COLOR_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define LGC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define LGC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/lgc_pkg.sv -----
// Types and constants of the linear gradient color block.
package lgc_pkg;

  localparam int unsigned COORD_W    = 16;
  localparam int unsigned DIFF_W     = COORD_W + 1;
  localparam int unsigned PROD_W     = 2 * DIFF_W;
  localparam int unsigned LEN_W      = PROD_W;
  localparam int unsigned DOT_W      = PROD_W + 1;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned RGBA_W     = 4 * CHAN_W;
  localparam int unsigned CFG_DATA_W = RGBA_W;
  localparam int unsigned CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_X    = 3'd0,
    CFG_START_Y    = 3'd1,
    CFG_STOP_X     = 3'd2,
    CFG_STOP_Y     = 3'd3,
    CFG_START_RGBA = 3'd4,
    CFG_STOP_RGBA  = 3'd5
  } lgc_cfg_idx_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
  } lgc_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } lgc_out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] stop_x;
    logic signed [COORD_W-1:0] stop_y;
    logic [RGBA_W-1:0]         start_rgba;
    logic [RGBA_W-1:0]         stop_rgba;
  } lgc_cfg_t;

  // Divider state carried from stage to stage
  typedef struct packed {
    logic [LEN_W-1:0] rem;
    logic [LEN_W-1:0] len2;
    logic             t_zero;
    logic             t_one;
  } lgc_div_t;

endpackage

// ----- rtl/core/linear_gradient_color.sv -----
// An item passes the projection, divider and blend registers from input accept to result valid.
// Throughput: one item per cycle while the output is not stalled; the divider gives one quotient bit per stage.
// Each stage holds its own valid bit, so bubbles collapse under output backpressure.
// Reset (rst_ni low, async) empties the pipe; start/stop points and start color
// clear to zero, stop color to all ones.
`include "linear_gradient_color_defines.svh"

module linear_gradient_color
  import lgc_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // position items in
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  lgc_in_t               in_item_i,
  // color items out
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output lgc_out_t              out_item_o
);

  localparam int unsigned T_W = FRAC_BITS + 1;
  localparam logic [T_W-1:0] ONE = T_W'(1) << FRAC_BITS;

  // Configuration registers. The user must see that they are written only while the pipe
  // is empty, so every stage can read them directly; the block does not enforce this.
  lgc_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_x    <= '0;
      cfg_q.start_y    <= '0;
      cfg_q.stop_x     <= '0;
      cfg_q.stop_y     <= '0;
      cfg_q.start_rgba <= '0;
      cfg_q.stop_rgba  <= '1;
    end else if (cfg_we_i) begin
      unique case (lgc_cfg_idx_e'(cfg_idx_i))
        CFG_START_X:    cfg_q.start_x    <= cfg_data_i[COORD_W-1:0];
        CFG_START_Y:    cfg_q.start_y    <= cfg_data_i[COORD_W-1:0];
        CFG_STOP_X:     cfg_q.stop_x     <= cfg_data_i[COORD_W-1:0];
        CFG_STOP_Y:     cfg_q.stop_y     <= cfg_data_i[COORD_W-1:0];
        CFG_START_RGBA: cfg_q.start_rgba <= cfg_data_i[RGBA_W-1:0];
        CFG_STOP_RGBA:  cfg_q.stop_rgba  <= cfg_data_i[RGBA_W-1:0];
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // Divider chain: index 0 is the projection output, index FRAC_BITS the
  // finished quotient.
  logic                 vld   [FRAC_BITS+1];
  logic                 rdy   [FRAC_BITS+1];
  lgc_div_t             div_s [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] q_s   [FRAC_BITS+1];
  logic [T_W-1:0]       t_div;

  // Three stages: differences, products, sums with clamp flags.
  lgc_proj u_proj (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .vld_i  (in_valid_i),
    .rdy_o  (in_ready_o),
    .item_i (in_item_i),
    .vld_o  (vld[0]),
    .rdy_i  (rdy[0]),
    .div_o  (div_s[0])
  );

  assign q_s[0] = '0;

  // Restoring division of dot << FRAC_BITS by len2, valid since 0 < dot < len2
  // on the unclamped path; clamped items just ride along.
  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
    lgc_div_step #(
      .FRAC_BITS (FRAC_BITS)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (vld[i]),
      .rdy_o  (rdy[i]),
      .div_i  (div_s[i]),
      .q_i    (q_s[i]),
      .vld_o  (vld[i+1]),
      .rdy_i  (rdy[i+1]),
      .div_o  (div_s[i+1]),
      .q_o    (q_s[i+1])
    );
  end

  // Clamp to 0..1 in Q1.FRAC_BITS
  always_comb begin
    if (div_s[FRAC_BITS].t_zero) begin
      t_div = '0;
    end else if (div_s[FRAC_BITS].t_one) begin
      t_div = ONE;
    end else begin
      t_div = {1'b0, q_s[FRAC_BITS]};
    end
  end

  // Two stages: channel products, then round-to-nearest sum into the
  // output register.
  lgc_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .vld_i        (vld[FRAC_BITS]),
    .rdy_o        (rdy[FRAC_BITS]),
    .t_i          (t_div),
    .start_rgba_i (cfg_q.start_rgba),
    .stop_rgba_i  (cfg_q.stop_rgba),
    .vld_o        (out_valid_o),
    .rdy_i        (out_ready_i),
    .item_o       (out_item_o)
  );

  // Input backpressure only ever comes from a stalled, full pipe.
  `LGC_ASSERT_NOW(a_in_stall_from_out, !in_ready_o, out_valid_o && !out_ready_i, "in stall without out stall")
  // Clamp flags are exclusive at the divider output.
  `LGC_ASSERT_NOW(a_clamp_excl, vld[FRAC_BITS], !(div_s[FRAC_BITS].t_zero && div_s[FRAC_BITS].t_one), "both clamp flags set")
  // A fully stalled pipe holds the fraction and the result.
  `LGC_ASSERT_NEXT(a_full_stall_holds, !in_ready_o && !out_ready_i, $stable(t_div) && $stable(out_item_o), "stalled pipe moved")

endmodule

// ----- rtl/core/lgc_proj.sv -----
// Projection front end: differences, products, dot product and squared length.
module lgc_proj
  import lgc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  lgc_cfg_t cfg_i,
  input  logic     vld_i,
  output logic     rdy_o,
  input  lgc_in_t  item_i,
  output logic     vld_o,
  input  logic     rdy_i,
  output lgc_div_t div_o
);

  logic vld_a_q, vld_b_q, vld_c_q;
  logic rdy_a, rdy_b, rdy_c;

  logic signed [DIFF_W-1:0] vx_d, vy_d, ax_d, ay_d;
  logic signed [DIFF_W-1:0] vx_q, vy_q, ax_q, ay_q;
  logic signed [PROD_W-1:0] p_d [4];
  logic signed [PROD_W-1:0] p_q [4];
  logic signed [DOT_W-1:0]  dot;
  logic [LEN_W-1:0]         len2;
  lgc_div_t                 div_d, div_q;

  assign rdy_c = !vld_c_q || rdy_i;
  assign rdy_b = !vld_b_q || rdy_c;
  assign rdy_a = !vld_a_q || rdy_b;
  assign rdy_o = rdy_a;

  // stage A: vectors relative to the start point
  assign vx_d = $signed({item_i.pos_x[COORD_W-1], item_i.pos_x})
              - $signed({cfg_i.start_x[COORD_W-1], cfg_i.start_x});
  assign vy_d = $signed({item_i.pos_y[COORD_W-1], item_i.pos_y})
              - $signed({cfg_i.start_y[COORD_W-1], cfg_i.start_y});
  assign ax_d = $signed({cfg_i.stop_x[COORD_W-1], cfg_i.stop_x})
              - $signed({cfg_i.start_x[COORD_W-1], cfg_i.start_x});
  assign ay_d = $signed({cfg_i.stop_y[COORD_W-1], cfg_i.stop_y})
              - $signed({cfg_i.start_y[COORD_W-1], cfg_i.start_y});

  // stage B: four 17x17 products
  always_comb begin
    p_d[0] = ax_q * vx_q;
    p_d[1] = ay_q * vy_q;
    p_d[2] = ax_q * ax_q;
    p_d[3] = ay_q * ay_q;
  end

  // stage C: sums and clamp classification
  assign dot  = $signed({p_q[0][PROD_W-1], p_q[0]}) + $signed({p_q[1][PROD_W-1], p_q[1]});
  assign len2 = p_q[2][LEN_W-1:0] + p_q[3][LEN_W-1:0];

  always_comb begin
    div_d.len2   = len2;
    div_d.t_zero = (len2 == '0) || dot[DOT_W-1] || (dot == '0);
    div_d.t_one  = !div_d.t_zero && (dot >= $signed({1'b0, len2}));
    div_d.rem    = (div_d.t_zero || div_d.t_one) ? '0 : dot[LEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
    end else begin
      if (rdy_a) vld_a_q <= vld_i;
      if (rdy_b) vld_b_q <= vld_a_q;
      if (rdy_c) vld_c_q <= vld_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && vld_i) begin
      vx_q <= vx_d;
      vy_q <= vy_d;
      ax_q <= ax_d;
      ay_q <= ay_d;
    end
    if (rdy_b && vld_a_q) begin
      p_q <= p_d;
    end
    if (rdy_c && vld_b_q) begin
      div_q <= div_d;
    end
  end

  assign vld_o = vld_c_q;
  assign div_o = div_q;

endmodule

// ----- rtl/core/lgc_div_step.sv -----
// One restoring division step: one quotient bit per stage.
module lgc_div_step
  import lgc_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 vld_i,
  output logic                 rdy_o,
  input  lgc_div_t             div_i,
  input  logic [FRAC_BITS-1:0] q_i,
  output logic                 vld_o,
  input  logic                 rdy_i,
  output lgc_div_t             div_o,
  output logic [FRAC_BITS-1:0] q_o
);

  logic                 vld_q;
  logic [LEN_W:0]       rem2, diff;
  logic                 ge;
  lgc_div_t             div_d, div_q;
  logic [FRAC_BITS-1:0] q_d, q_q;

  assign rdy_o = !vld_q || rdy_i;

  // remainder stays below len2, so the difference fits LEN_W bits
  assign rem2 = {div_i.rem, 1'b0};
  assign diff = rem2 - {1'b0, div_i.len2};
  assign ge   = rem2 >= {1'b0, div_i.len2};

  always_comb begin
    div_d     = div_i;
    div_d.rem = ge ? diff[LEN_W-1:0] : rem2[LEN_W-1:0];
    q_d       = {q_i[FRAC_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_i) begin
      div_q <= div_d;
      q_q   <= q_d;
    end
  end

  assign vld_o = vld_q;
  assign div_o = div_q;
  assign q_o   = q_q;

endmodule

// ----- rtl/core/lgc_blend.sv -----
// Per-channel color blend: weighted products, then rounded sum.
module lgc_blend
  import lgc_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  output logic               rdy_o,
  input  logic [FRAC_BITS:0] t_i,
  input  logic [RGBA_W-1:0]  start_rgba_i,
  input  logic [RGBA_W-1:0]  stop_rgba_i,
  output logic               vld_o,
  input  logic               rdy_i,
  output lgc_out_t           item_o
);

  localparam int unsigned T_W = FRAC_BITS + 1;
  localparam int unsigned P_W = FRAC_BITS + CHAN_W + 1;
  localparam logic [T_W-1:0] ONE  = T_W'(1) << FRAC_BITS;
  localparam logic [P_W-1:0] HALF = P_W'(1) << (FRAC_BITS - 1);

  logic              vld_a_q, vld_b_q;
  logic              rdy_a, rdy_b;
  logic [T_W-1:0]    t_inv;
  logic [P_W-1:0]    pa_d [4];
  logic [P_W-1:0]    pb_d [4];
  logic [P_W-1:0]    pa_q [4];
  logic [P_W-1:0]    pb_q [4];
  logic [P_W-1:0]    acc  [4];
  logic [CHAN_W-1:0] ch_d [4];
  lgc_out_t          out_q;

  assign rdy_b = !vld_b_q || rdy_i;
  assign rdy_a = !vld_a_q || rdy_b;
  assign rdy_o = rdy_a;

  assign t_inv = ONE - t_i;

  // channel 0 is red in the top byte
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pa_d[k] = P_W'(start_rgba_i[RGBA_W-1-CHAN_W*k -: CHAN_W]) * P_W'(t_inv);
      pb_d[k] = P_W'(stop_rgba_i[RGBA_W-1-CHAN_W*k -: CHAN_W]) * P_W'(t_i);
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      acc[k]  = pa_q[k] + pb_q[k] + HALF;
      ch_d[k] = acc[k][FRAC_BITS +: CHAN_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      if (rdy_a) vld_a_q <= vld_i;
      if (rdy_b) vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && vld_i) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
    end
    if (rdy_b && vld_a_q) begin
      out_q.red   <= ch_d[0];
      out_q.green <= ch_d[1];
      out_q.blue  <= ch_d[2];
      out_q.alpha <= ch_d[3];
    end
  end

  assign vld_o  = vld_b_q;
  assign item_o = out_q;

endmodule
